// File: rtl/speck32_block_cipher_core_macros.svh
// Assertion helpers shared by the cipher RTL.
`ifndef SPECK32_BLOCK_CIPHER_CORE_MACROS_SVH
`define SPECK32_BLOCK_CIPHER_CORE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define SPK32_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spk32 same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define SPK32_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spk32 next-cycle check failed");

`endif

// File: rtl/spk32_pkg.sv
package spk32_pkg;

   localparam int WORD_BITS     = 16;
   localparam int BLOCK_BITS    = 2 * WORD_BITS;
   localparam int MAX_ROUNDS    = 22;
   localparam int MAX_KEY_WORDS = 4;
   localparam int L_WORDS       = MAX_KEY_WORDS - 1;
   localparam int L_IDX_BITS    = (L_WORDS > 1) ? $clog2(L_WORDS) : 1;

   localparam int ROT_A = 7 + ((WORD_BITS != 16) ? 1 : 0);
   localparam int ROT_B = 2 + ((WORD_BITS != 16) ? 1 : 0);

   localparam int RK_IDX_BITS    = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
   localparam int ROUND_USE_BITS = $clog2(MAX_ROUNDS + 1);

   // Field widths of the register file
   localparam int KEY_WORD_BITS    = 16;
   localparam int KEY_LENGTH_BITS  = 3;
   localparam int ROUND_COUNT_BITS = 5;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 16;

   localparam logic [KEY_LENGTH_BITS-1:0]  KEY_LENGTH_RESET  = 3'd4;
   localparam logic [ROUND_COUNT_BITS-1:0] ROUND_COUNT_RESET = 5'd22;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KEY_WORD_0  = 3'd0,
      CSR_KEY_WORD_1  = 3'd1,
      CSR_KEY_WORD_2  = 3'd2,
      CSR_KEY_WORD_3  = 3'd3,
      CSR_KEY_LENGTH  = 3'd4,
      CSR_ROUND_COUNT = 3'd5
   } csr_index_type;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [MAX_ROUNDS-1:0][WORD_BITS-1:0] rk_array_type;

   // One block moving down the round chain
   typedef struct packed {
      logic     valid;
      logic     op;
      word_type left;
      word_type right;
   } beat_type;

   typedef struct packed {
      logic [MAX_KEY_WORDS-1:0][WORD_BITS-1:0] key_word;
      logic [KEY_LENGTH_BITS-1:0]              key_length;
   } key_cfg_type;

   typedef struct packed {
      logic ready;
      logic loading;
   } ks_status_type;

   function automatic word_type rot_r(input word_type x, input int n);
      rot_r = (x >> n) | (x << (WORD_BITS - n));
   endfunction

   function automatic word_type rot_l(input word_type x, input int n);
      rot_l = (x << n) | (x >> (WORD_BITS - n));
   endfunction

endpackage

// File: rtl/spk32_if.sv
interface spk32_req_if;
   logic                           valid;
   logic                           ready;
   logic                           op;
   logic [spk32_pkg::BLOCK_BITS-1:0] data_in;

   modport source (output valid, output op, output data_in, input ready);
   modport sink   (input valid, input op, input data_in, output ready);
endinterface

interface spk32_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [spk32_pkg::BLOCK_BITS-1:0] data_out;

   modport source (output valid, output data_out, input ready);
   modport sink   (input valid, input data_out, output ready);
endinterface

// File: rtl/speck32_block_cipher_core.sv
// Speck32 block cipher core: 16-bit words, 1..22 rounds, 2..4 key words.
// Each accepted request beat passes through the cells of the round chain in
// order while the chain advances; inactive cells pass the block through.
// Throughput: up to one block per cycle while the keys are ready and the response side keeps up.
// Reset (synchronous, active high) loads default registers and expands keys;
// each register write restarts expansion with req_chan.ready low.
`include "speck32_block_cipher_core_macros.svh"

module speck32_block_cipher_core (
   input  logic                                  clock,
   input  logic                                  reset,
   spk32_req_if.sink                             req_chan,
   spk32_rsp_if.source                           rsp_chan,
   input  logic                                  csr_write_en,
   input  logic [spk32_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [spk32_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   localparam int LAST = spk32_pkg::MAX_ROUNDS - 1;

   // Register file
   logic [spk32_pkg::MAX_KEY_WORDS-1:0][spk32_pkg::KEY_WORD_BITS-1:0] key_word_ff;
   logic [spk32_pkg::KEY_LENGTH_BITS-1:0]  key_length_ff;
   logic [spk32_pkg::ROUND_COUNT_BITS-1:0] round_count_ff;
   logic                                   csr_hit;

   logic [spk32_pkg::ROUND_USE_BITS-1:0]   rounds_used;

   spk32_pkg::key_cfg_type                 key_cfg;
   spk32_pkg::rk_array_type                round_keys;
   spk32_pkg::ks_status_type               ks_stat;

   spk32_pkg::beat_type                    req_beat;
   spk32_pkg::beat_type [spk32_pkg::MAX_ROUNDS-1:0] cell_q;
   logic                                   advance;
   logic                                   req_fire;

   // Decode register writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         key_word_ff    <= '0;
         key_length_ff  <= spk32_pkg::KEY_LENGTH_RESET;
         round_count_ff <= spk32_pkg::ROUND_COUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            spk32_pkg::CSR_KEY_WORD_0:  key_word_ff[0] <= csr_write_data;
            spk32_pkg::CSR_KEY_WORD_1:  key_word_ff[1] <= csr_write_data;
            spk32_pkg::CSR_KEY_WORD_2:  key_word_ff[2] <= csr_write_data;
            spk32_pkg::CSR_KEY_WORD_3:  key_word_ff[3] <= csr_write_data;
            spk32_pkg::CSR_KEY_LENGTH:
               key_length_ff  <= csr_write_data[spk32_pkg::KEY_LENGTH_BITS-1:0];
            spk32_pkg::CSR_ROUND_COUNT:
               round_count_ff <= csr_write_data[spk32_pkg::ROUND_COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Any write to a listed register invalidates the expanded keys
   assign csr_hit = csr_write_en
                 && (csr_index <= spk32_pkg::CSR_INDEX_BITS'(spk32_pkg::CSR_ROUND_COUNT));

   // Clamp round count: zero acts as one, large values saturate
   always_comb begin
      if (round_count_ff == '0) begin
         rounds_used = spk32_pkg::ROUND_USE_BITS'(1);
      end else if (32'(round_count_ff) > spk32_pkg::MAX_ROUNDS) begin
         rounds_used = spk32_pkg::ROUND_USE_BITS'(spk32_pkg::MAX_ROUNDS);
      end else begin
         rounds_used = spk32_pkg::ROUND_USE_BITS'(round_count_ff);
      end
   end

   assign key_cfg.key_word   = key_word_ff;
   assign key_cfg.key_length = key_length_ff;

   spk32_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_hit),
      .key_cfg    (key_cfg),
      .round_keys (round_keys),
      .status     (ks_stat)
   );

   // Whole chain advances together; hold it only when the last cell's
   // result is stalled at the response port
   assign advance        = !cell_q[LAST].valid || rsp_chan.ready;
   assign req_chan.ready = ks_stat.ready && advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign req_beat.valid = req_fire;
   assign req_beat.op    = req_chan.op;
   assign req_beat.left  = req_chan.data_in[spk32_pkg::WORD_BITS-1:0];
   assign req_beat.right = req_chan.data_in[spk32_pkg::BLOCK_BITS-1:spk32_pkg::WORD_BITS];

   // Cell j runs forward round j, or inverse round MAX_ROUNDS-1-j, so that
   // decryption walks the key table downward and ends on round key zero
   for (genvar j = 0; j < spk32_pkg::MAX_ROUNDS; j++) begin : g_cell
      spk32_pkg::beat_type cell_in;
      logic                act_enc;
      logic                act_dec;

      if (j == 0) begin : g_head
         assign cell_in = req_beat;
      end else begin : g_link
         assign cell_in = cell_q[j-1];
      end

      assign act_enc = spk32_pkg::ROUND_USE_BITS'(j) < rounds_used;
      assign act_dec = spk32_pkg::ROUND_USE_BITS'(LAST - j) < rounds_used;

      spk32_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .beat_in  (cell_in),
         .key_enc  (round_keys[j]),
         .key_dec  (round_keys[LAST - j]),
         .act_enc  (act_enc),
         .act_dec  (act_dec),
         .beat_out (cell_q[j])
      );
   end

   // Response beat comes straight off the last cell
   assign rsp_chan.valid    = cell_q[LAST].valid;
   assign rsp_chan.data_out = {cell_q[LAST].right, cell_q[LAST].left};

   `SPK32_ASSERT_NOW(a_accept_needs_keys, clock, reset, req_fire, ks_stat.ready)
   `SPK32_ASSERT_NEXT(a_write_restarts_keys, clock, reset, csr_hit, ks_stat.loading)
   `SPK32_ASSERT_NEXT(a_accept_enters_chain, clock, reset, req_fire, cell_q[0].valid)

endmodule

// File: rtl/spk32_cell.sv
module spk32_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  spk32_pkg::beat_type beat_in,
   input  spk32_pkg::word_type key_enc,
   input  spk32_pkg::word_type key_dec,
   input  logic                act_enc,
   input  logic                act_dec,
   output spk32_pkg::beat_type beat_out
);

   logic                valid_ff;
   logic                op_ff;
   spk32_pkg::word_type left_ff, left_in;
   spk32_pkg::word_type right_ff, right_in;
   spk32_pkg::word_type enc_l, enc_r, dec_l, dec_r, dec_d;
   logic                is_dec;

   // Forward round
   assign enc_l = (spk32_pkg::rot_r(beat_in.left, spk32_pkg::ROT_A) + beat_in.right) ^ key_enc;
   assign enc_r = spk32_pkg::rot_l(beat_in.right, spk32_pkg::ROT_B) ^ enc_l;

   // Inverse round
   assign dec_r = spk32_pkg::rot_r(beat_in.left ^ beat_in.right, spk32_pkg::ROT_B);
   assign dec_d = (beat_in.left ^ key_dec) - dec_r;
   assign dec_l = spk32_pkg::rot_l(dec_d, spk32_pkg::ROT_A);

   assign is_dec = (beat_in.op == spk32_pkg::OP_DECRYPT);

   always_comb begin
      left_in  = beat_in.left;
      right_in = beat_in.right;
      if (is_dec && act_dec) begin
         left_in  = dec_l;
         right_in = dec_r;
      end else if (!is_dec && act_enc) begin
         left_in  = enc_l;
         right_in = enc_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= beat_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff    <= beat_in.op;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign beat_out.valid = valid_ff;
   assign beat_out.op    = op_ff;
   assign beat_out.left  = left_ff;
   assign beat_out.right = right_ff;

endmodule

// File: rtl/spk32_key_sched.sv
module spk32_key_sched (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     restart,
   input  spk32_pkg::key_cfg_type   key_cfg,
   output spk32_pkg::rk_array_type  round_keys,
   output spk32_pkg::ks_status_type status
);

   typedef enum logic [2:0] {
      KS_LOAD = 3'b001,
      KS_RUN  = 3'b010,
      KS_DONE = 3'b100
   } ks_state_type;

   localparam logic [spk32_pkg::RK_IDX_BITS-1:0] LAST_IDX =
      spk32_pkg::RK_IDX_BITS'(spk32_pkg::MAX_ROUNDS - 1);

   ks_state_type                                  state_ff, state_in;
   logic [spk32_pkg::RK_IDX_BITS-1:0]             idx_ff, idx_in;
   spk32_pkg::word_type                           k_ff, k_in;
   spk32_pkg::word_type [spk32_pkg::L_WORDS-1:0]  lw_ff, lw_in;
   spk32_pkg::rk_array_type                       rk_ff;
   logic [spk32_pkg::L_IDX_BITS-1:0]              last_slot;
   logic [spk32_pkg::RK_IDX_BITS-1:0]             idx_prev;
   spk32_pkg::word_type                           nxt;
   logic                                          rk_we;
   spk32_pkg::word_type                           rk_wdata;

   // Number of l-words in use, less one, as the top slot of the queue
   always_comb begin
      if (32'(key_cfg.key_length) < 2) begin
         last_slot = '0;
      end else if (32'(key_cfg.key_length) > spk32_pkg::MAX_KEY_WORDS) begin
         last_slot = spk32_pkg::L_IDX_BITS'(spk32_pkg::MAX_KEY_WORDS - 2);
      end else begin
         last_slot = spk32_pkg::L_IDX_BITS'(key_cfg.key_length - 3'd2);
      end
   end

   assign idx_prev = idx_ff - 1'b1;
   assign nxt = (k_ff + spk32_pkg::rot_r(lw_ff[0], spk32_pkg::ROT_A))
              ^ spk32_pkg::WORD_BITS'(idx_prev);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      k_in     = k_ff;
      lw_in    = lw_ff;
      rk_we    = 1'b0;
      rk_wdata = k_ff;
      unique case (state_ff)
         KS_LOAD: begin
            k_in     = key_cfg.key_word[0];
            rk_we    = 1'b1;
            rk_wdata = key_cfg.key_word[0];
            for (int i = 0; i < spk32_pkg::L_WORDS; i++) begin
               lw_in[i] = key_cfg.key_word[i + 1];
            end
            idx_in   = (spk32_pkg::MAX_ROUNDS > 1) ? spk32_pkg::RK_IDX_BITS'(1) : '0;
            state_in = (spk32_pkg::MAX_ROUNDS > 1) ? KS_RUN : KS_DONE;
         end
         KS_RUN: begin
            // Consume the head l-word, append the new one at the tail
            k_in     = spk32_pkg::rot_l(k_ff, spk32_pkg::ROT_B) ^ nxt;
            rk_we    = 1'b1;
            rk_wdata = k_in;
            for (int i = 0; i < spk32_pkg::L_WORDS; i++) begin
               if (spk32_pkg::L_IDX_BITS'(i) == last_slot) begin
                  lw_in[i] = nxt;
               end else if (i + 1 < spk32_pkg::L_WORDS) begin
                  lw_in[i] = lw_ff[i + 1];
               end
            end
            if (idx_ff == LAST_IDX) begin
               state_in = KS_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         KS_DONE: begin
            state_in = KS_DONE;
         end
         default: begin
            state_in = KS_LOAD;
         end
      endcase
      // Rewind to slot zero so the load writes round key zero
      if (restart) begin
         state_in = KS_LOAD;
         idx_in   = '0;
         rk_we    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KS_LOAD;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff  <= k_in;
      lw_ff <= lw_in;
      if (rk_we) begin
         rk_ff[idx_ff] <= rk_wdata;
      end
   end

   assign round_keys     = rk_ff;
   assign status.ready   = (state_ff == KS_DONE);
   assign status.loading = (state_ff == KS_LOAD);

endmodule
